@@ rtl/stepper_position_pulse_generator_unit_assert.svh @@
// Assertion macros used by the checker of the step pulse generator.
// Both sample on clk and stay quiet while rst is high.
`ifndef STEPPER_POSITION_PULSE_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_POSITION_PULSE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SPPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sppg_pkg.sv @@
`default_nettype none

package sppg_pkg;

  localparam int POS_WIDTH_DEF = 32;

  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int FREQ_W   = 17;
  localparam int COUNT_W  = 32;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 3;

  // Request kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ABS  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREQ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_AT_TARGET = 3'd4;

  localparam int TIMEBASE_HZ = 1000000;
  localparam int FREQ_MIN    = 20;
  localparam int FREQ_MAX    = 100000;

  // Restoring divider over the timebase constant, one quotient bit a step
  localparam int DIV_W     = $clog2(TIMEBASE_HZ + 1);
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int IN_FIELDS_W  = VALUE_W + FREQ_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 + VALUE_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_MOVING_BIT = 2;
  localparam int OUT_STATUS_LSB = 3 + VALUE_W;

  // Packed with the first field in the highest bits
  typedef struct packed {
    logic                       move_direction;
    logic [FREQ_W-1:0]          step_frequency;
    logic signed [VALUE_W-1:0]  move_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  position;
    logic                       moving;
    logic                       dir_level;
    logic                       step_level;
  } out_item_t;

  typedef struct packed {
    logic exec;       // apply an item that needs no division and report it
    logic start_div;  // latch an accepted move and start the period division
    logic load_move;  // load the divided period and start pulsing
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_go;    // current input is a move that will be accepted
    logic div_done;   // period quotient is ready
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/sppg_divider.sv @@
`default_nettype none

module sppg_divider (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [sppg_pkg::FREQ_W-1:0]        divisor,
  output logic                                    done,
  output logic [sppg_pkg::PERIOD_W-1:0]           quotient
);

  localparam int DW = sppg_pkg::DIV_W;
  localparam int FW = sppg_pkg::FREQ_W;

  logic                             busy;
  logic [sppg_pkg::DIV_CNT_W-1:0]   cnt;
  logic [FW-1:0]                    dvs;
  logic [FW-1:0]                    rem;
  logic [DW-1:0]                    dvd;
  logic [DW-1:0]                    quo;
  logic [FW:0]                      trial;
  logic                             fits;

  assign trial    = {rem, dvd[DW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo[sppg_pkg::PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= sppg_pkg::DIV_CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - sppg_pkg::DIV_CNT_W'(1);
        if (cnt == sppg_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      dvd <= DW'(sppg_pkg::TIMEBASE_HZ);
      quo <= '0;
    end else if (busy) begin
      // one restoring step: shift in the next dividend bit, subtract if it fits
      rem <= fits ? FW'(trial - {1'b0, dvs}) : trial[FW-1:0];
      quo <= {quo[DW-2:0], fits};
      dvd <= {dvd[DW-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

@@ rtl/sppg_datapath.sv @@
`default_nettype none

module sppg_datapath #(
  parameter int POS_WIDTH = sppg_pkg::POS_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [sppg_pkg::REQ_W-1:0]    req,
  input  wire sppg_pkg::in_item_t            item,
  input  wire sppg_pkg::ctrl_cmd_t           cmd,
  output sppg_pkg::dp_stat_t                 stat,
  output sppg_pkg::out_item_t                res
);

  localparam int VW    = sppg_pkg::VALUE_W;
  localparam int CW    = sppg_pkg::COUNT_W;
  localparam int PW    = sppg_pkg::PERIOD_W;
  localparam int FW    = sppg_pkg::FREQ_W;
  localparam int CMP_W = (POS_WIDTH > VW ? POS_WIDTH : VW) + 1;

  logic [POS_WIDTH-1:0]  position_count, position_count_next;
  logic [CW-1:0]         pulses_left, pulses_left_next;
  logic [PW-1:0]         period_reload, period_reload_next;
  logic [PW-1:0]         tick_count, tick_count_next;
  logic                  busy_flag, busy_flag_next;
  logic                  dir_reg, dir_reg_next;

  logic [CW-1:0]         pend_count;
  logic                  pend_dir;

  logic                  div_done;
  logic [PW-1:0]         div_quo;

  logic                  level;
  logic                  freq_ok;
  logic                  count_bad;
  logic [CMP_W-1:0]      cur_ext, val_ext, diff, mag;
  logic                  abs_cw;
  logic [CW-1:0]         abs_count;
  logic [sppg_pkg::STATUS_W-1:0] status;
  logic                  go;
  logic [CW-1:0]         go_count;
  logic                  go_dir;
  logic [VW-1:0]         pos_low;

  sppg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .divisor  (item.step_frequency),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign level     = busy_flag && (tick_count >= (period_reload >> 1));
  assign freq_ok   = (item.step_frequency >= FW'(sppg_pkg::FREQ_MIN)) &&
                     (item.step_frequency <= FW'(sppg_pkg::FREQ_MAX));
  assign count_bad = item.move_value[VW-1] || (item.move_value == '0);

  // Absolute distance against the sign-extended position
  assign cur_ext   = {{(CMP_W-POS_WIDTH){position_count[POS_WIDTH-1]}}, position_count};
  assign val_ext   = {{(CMP_W-VW){item.move_value[VW-1]}}, item.move_value};
  assign diff      = val_ext - cur_ext;
  assign abs_cw    = !diff[CMP_W-1] && (diff != '0);
  assign mag       = diff[CMP_W-1] ? (~diff + CMP_W'(1)) : diff;
  assign abs_count = (mag[CMP_W-1:CW] != '0) ? '1 : mag[CW-1:0];

  always_comb begin
    status   = sppg_pkg::ST_OK;
    go       = 1'b0;
    go_count = item.move_value;
    go_dir   = !item.move_direction;
    case (req)
      sppg_pkg::REQ_REL: begin
        if (count_bad) status = sppg_pkg::ST_BAD_COUNT;
        else if (busy_flag) status = sppg_pkg::ST_BUSY;
        else if (!freq_ok) status = sppg_pkg::ST_BAD_FREQ;
        else go = 1'b1;
      end
      sppg_pkg::REQ_ABS: begin
        go_count = abs_count;
        go_dir   = abs_cw;
        if (busy_flag) status = sppg_pkg::ST_BUSY;
        else if (!freq_ok) status = sppg_pkg::ST_BAD_FREQ;
        else if (diff == '0) status = sppg_pkg::ST_AT_TARGET;
        else go = 1'b1;
      end
      default: begin
        status = sppg_pkg::ST_OK;
      end
    endcase
  end

  assign stat.move_go  = go;
  assign stat.div_done = div_done;

  always_comb begin
    position_count_next = position_count;
    pulses_left_next    = pulses_left;
    period_reload_next  = period_reload;
    tick_count_next     = tick_count;
    busy_flag_next      = busy_flag;
    dir_reg_next        = dir_reg;
    if (cmd.exec && (req == sppg_pkg::REQ_TICK) && busy_flag) begin
      if (tick_count >= period_reload) begin
        // end of pulse: step the position, reload the period
        position_count_next = dir_reg ? position_count + POS_WIDTH'(1)
                                      : position_count - POS_WIDTH'(1);
        tick_count_next     = '0;
        pulses_left_next    = pulses_left - CW'(1);
        if (pulses_left == CW'(1)) busy_flag_next = 1'b0;
      end else begin
        tick_count_next = tick_count + PW'(1);
      end
    end
    if (cmd.load_move) begin
      dir_reg_next       = pend_dir;
      pulses_left_next   = pend_count;
      period_reload_next = div_quo - PW'(1);
      tick_count_next    = '0;
      busy_flag_next     = 1'b1;
    end
  end

  if (POS_WIDTH >= VW) begin : g_pos_wide
    assign pos_low = position_count_next[VW-1:0];
  end else begin : g_pos_narrow
    assign pos_low = {{(VW-POS_WIDTH){1'b0}}, position_count_next};
  end

  assign res.step_level = level;
  assign res.dir_level  = dir_reg_next;
  assign res.moving     = busy_flag_next;
  assign res.position   = pos_low;
  assign res.status     = cmd.load_move ? sppg_pkg::ST_OK : status;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      pulses_left    <= '0;
      period_reload  <= '0;
      tick_count     <= '0;
      busy_flag      <= 1'b0;
      dir_reg        <= 1'b1;
    end else begin
      position_count <= position_count_next;
      pulses_left    <= pulses_left_next;
      period_reload  <= period_reload_next;
      tick_count     <= tick_count_next;
      busy_flag      <= busy_flag_next;
      dir_reg        <= dir_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      pend_count <= go_count;
      pend_dir   <= go_dir;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sppg_ctrl.sv @@
`default_nettype none

module sppg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 space,
  input  wire sppg_pkg::dp_stat_t   stat,
  output logic                      in_ready,
  output sppg_pkg::ctrl_cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic state, state_next;
  logic in_fire;

  assign in_ready = !rst && (state == S_IDLE) && space;
  assign in_fire  = in_valid && in_ready;

  assign cmd.exec      = in_fire && !stat.move_go;
  assign cmd.start_div = in_fire && stat.move_go;
  assign cmd.load_move = (state == S_DIV) && stat.div_done;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.start_div) state_next = S_DIV;
      S_DIV:  if (stat.div_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sppg_outbuf.sv @@
`default_nettype none

module sppg_outbuf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sppg_pkg::out_item_t  item,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output sppg_pkg::out_item_t       out_item,
  output logic                      space
);

  logic [1:0]           count;
  sppg_pkg::out_item_t  slot0, slot1;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign out_item  = slot0;
  assign space     = count != 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // advance the queue; a new word lands behind whatever is left
      if (count == 2'd2) begin
        slot0 <= slot1;
        if (push) slot1 <= item;
      end else if (push) begin
        slot0 <= item;
      end
    end else if (push) begin
      if (count == 2'd0) slot0 <= item;
      else slot1 <= item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stepper_position_pulse_generator_unit.sv @@
// Step/direction pulse generator for one stepper axis with a wrapping position.
// Input channel s_axis: one word per request. tuser is the request kind
// (timebase tick, relative move, absolute move); tdata carries the move value,
// step frequency and direction. Output channel m_axis: exactly one result word
// per input word, in order: step pin level, direction pin, moving flag,
// position and a status code.
// Ticks, unused kinds and rejected moves can stream back to back while the
// output queue has space; their result is held in the queue the cycle after the word is taken.
// An accepted move runs a 20-step restoring division of the 1 MHz timebase by
// the step frequency, one quotient bit per cycle; s_axis_tready stays low until
// the quotient is loaded and the move's result word is pushed to the queue.
// A two-word output queue sits between the channels, so input keeps flowing
// while one result waits; when the receiver stalls and the queue fills,
// s_axis_tready drops until a word is taken.
// Synchronous reset: position zero, idle, direction clockwise, queue empty,
// s_axis_tready low while rst is high.
`default_nettype none

module stepper_position_pulse_generator_unit #(
  parameter int POS_WIDTH = sppg_pkg::POS_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [31:0] move_value, [48:32] step_frequency, [49] move_direction, rest zero
  input  wire logic [sppg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] req_type
  input  wire logic [sppg_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] step_level, [1] dir_level, [2] moving, [34:3] position,
  // [37:35] status, rest zero
  output logic [sppg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  sppg_pkg::in_item_t   in_item;
  sppg_pkg::out_item_t  result;
  sppg_pkg::out_item_t  head;
  sppg_pkg::ctrl_cmd_t  cmd;
  sppg_pkg::dp_stat_t   stat;
  logic                 space;

  // drop the padding bits of the input word
  assign in_item = s_axis_tdata[sppg_pkg::IN_FIELDS_W-1:0];

  sppg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .space    (space),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  sppg_datapath #(
    .POS_WIDTH (POS_WIDTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (s_axis_tuser),
    .item (in_item),
    .cmd  (cmd),
    .stat (stat),
    .res  (result)
  );

  // every executed item and every loaded move yields one result word
  sppg_outbuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd.exec || cmd.load_move),
    .item      (result),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_item  (head),
    .space     (space)
  );

  assign m_axis_tdata = {{(sppg_pkg::OUT_TDATA_W-sppg_pkg::OUT_FIELDS_W){1'b0}}, head};

endmodule

`default_nettype wire

@@ rtl/sppg_checker.sv @@
`default_nettype none

`include "stepper_position_pulse_generator_unit_assert.svh"

module sppg_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [sppg_pkg::REQ_W-1:0]       s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [sppg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [sppg_pkg::STATUS_W-1:0] status;
  logic                          moving;
  logic                          tick_in;

  assign status  = m_axis_tdata[sppg_pkg::OUT_STATUS_LSB +: sppg_pkg::STATUS_W];
  assign moving  = m_axis_tdata[sppg_pkg::OUT_MOVING_BIT];
  assign tick_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == sppg_pkg::REQ_TICK);

  // a stalled result word holds
  `SPPG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // a move refused as busy leaves the axis moving
  `SPPG_ASSERT_SAME(a_busy_moving, m_axis_tvalid && (status == sppg_pkg::ST_BUSY), moving, "busy status reported while idle")

  // frequency and at-target rejections only happen while idle
  `SPPG_ASSERT_SAME(a_idle_reject, m_axis_tvalid && (status == sppg_pkg::ST_BAD_FREQ || status == sppg_pkg::ST_AT_TARGET), !moving, "idle rejection reported while moving")

  // reset empties the output queue
  `SPPG_ASSERT_SAME(a_reset_empty, $past(rst), !m_axis_tvalid, "result word present after reset")

  // a tick taken into an empty queue shows its result next cycle
  `SPPG_ASSERT_NEXT(a_tick_result, tick_in && !m_axis_tvalid, m_axis_tvalid, "tick result missing")

endmodule

bind stepper_position_pulse_generator_unit sppg_checker u_checker (.*);

`default_nettype wire
